FILE: rtl/small_tag_set_union_core_macros.svh
// Assertion macros used by the checker file of the tag set union block.
`ifndef SMALL_TAG_SET_UNION_CORE_MACROS_SVH
`define SMALL_TAG_SET_UNION_CORE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SSTU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sstu assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SSTU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sstu assertion failed");

`endif

FILE: rtl/sstu_pkg.sv
package sstu_pkg;

   localparam int TAG_SLOTS             = 4;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;
   localparam int COUNT_W               = $clog2(TAG_SLOTS + 1);
   localparam int SLOT_IDX_W            = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

   typedef struct packed {
      logic live;
      logic found;
   } lane_flags_type;

   function automatic logic [TAG_SLOTS-1:0] prefix_mask(input logic [TAG_SLOTS-1:0] nonzero);
      logic [TAG_SLOTS-1:0] mask;
      logic                 run;
      mask = '0;
      run  = 1'b1;
      for (int i = 0; i < TAG_SLOTS; i++) begin
         run     = run & nonzero[i];
         mask[i] = run;
      end
      return mask;
   endfunction

   function automatic logic [COUNT_W-1:0] count_ones(input logic [TAG_SLOTS-1:0] mask);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < TAG_SLOTS; i++) begin
         n = n + COUNT_W'(mask[i]);
      end
      return n;
   endfunction

endpackage

FILE: rtl/sstu_lane.sv
module sstu_lane #(
   parameter int ELEMENT_WIDTH = sstu_pkg::ELEMENT_WIDTH_DEFAULT,
   parameter int LANE_INDEX    = 0
) (
   input  logic [ELEMENT_WIDTH-1:0]     left_slots  [sstu_pkg::TAG_SLOTS],
   input  logic [ELEMENT_WIDTH-1:0]     right_slots [sstu_pkg::TAG_SLOTS],
   input  logic [sstu_pkg::TAG_SLOTS-1:0] left_live,
   output sstu_pkg::lane_flags_type     flags
);

   // A right element is already present if it matches a live left element or an
   // earlier right element, since that earlier element was either added or found.
   always_comb begin
      logic live;
      logic found;
      live  = 1'b1;
      found = 1'b0;
      for (int k = 0; k <= LANE_INDEX; k++) begin
         live = live & (right_slots[k] != '0);
      end
      for (int i = 0; i < sstu_pkg::TAG_SLOTS; i++) begin
         if (left_live[i] && (left_slots[i] == right_slots[LANE_INDEX])) begin
            found = 1'b1;
         end
      end
      for (int k = 0; k < LANE_INDEX; k++) begin
         if (right_slots[k] == right_slots[LANE_INDEX]) begin
            found = 1'b1;
         end
      end
      flags.live  = live;
      flags.found = found;
   end

endmodule

FILE: rtl/sstu_merge.sv
module sstu_merge #(
   parameter int ELEMENT_WIDTH = sstu_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic [ELEMENT_WIDTH-1:0]       left_slots   [sstu_pkg::TAG_SLOTS],
   input  logic [ELEMENT_WIDTH-1:0]       right_slots  [sstu_pkg::TAG_SLOTS],
   input  logic [sstu_pkg::COUNT_W-1:0]   left_count,
   input  sstu_pkg::lane_flags_type       flags        [sstu_pkg::TAG_SLOTS],
   input  logic                           any_full,
   output logic [ELEMENT_WIDTH-1:0]       merged_slots [sstu_pkg::TAG_SLOTS],
   output logic                           saturated
);

   always_comb begin
      logic                         overflow;
      logic [sstu_pkg::COUNT_W-1:0] cnt;
      overflow = 1'b0;
      cnt      = left_count;
      for (int i = 0; i < sstu_pkg::TAG_SLOTS; i++) begin
         merged_slots[i] = '0;
      end
      if (left_count == '0) begin
         // An empty left set passes the right set through unchanged.
         for (int i = 0; i < sstu_pkg::TAG_SLOTS; i++) begin
            merged_slots[i] = flags[i].live ? right_slots[i] : '0;
         end
      end else begin
         for (int i = 0; i < sstu_pkg::TAG_SLOTS; i++) begin
            if (sstu_pkg::COUNT_W'(i) < left_count) begin
               merged_slots[i] = left_slots[i];
            end
         end
         for (int j = 0; j < sstu_pkg::TAG_SLOTS; j++) begin
            if (flags[j].live && !flags[j].found) begin
               if (cnt >= sstu_pkg::COUNT_W'(sstu_pkg::TAG_SLOTS)) begin
                  overflow = 1'b1;
               end else begin
                  merged_slots[cnt[sstu_pkg::SLOT_IDX_W-1:0]] = right_slots[j];
                  cnt = cnt + sstu_pkg::COUNT_W'(1);
               end
            end
         end
      end
      saturated = any_full | overflow;
      if (saturated) begin
         for (int i = 0; i < sstu_pkg::TAG_SLOTS; i++) begin
            merged_slots[i] = '0;
         end
         merged_slots[0] = '1;
      end
   end

endmodule

FILE: rtl/small_tag_set_union_core.sv
// An input transfer is registered in the lane stage, then in the merge stage, before its result is offered on rsp_.
// Throughput: one item per cycle while rsp_ is not stalled; one compare lane per right slot, then a merge stage.
// While a result is stalled on rsp_, one more item can still enter an empty lane stage;
// once both stages hold an item, req_stall follows rsp_stall.
// Reset clears both pipeline valid bits; payload registers are not reset.
module small_tag_set_union_core #(
   parameter int ELEMENT_WIDTH = sstu_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ELEMENT_WIDTH-1:0] req_left_slot_0,
   input  logic [ELEMENT_WIDTH-1:0] req_left_slot_1,
   input  logic [ELEMENT_WIDTH-1:0] req_left_slot_2,
   input  logic [ELEMENT_WIDTH-1:0] req_left_slot_3,
   input  logic [ELEMENT_WIDTH-1:0] req_right_slot_0,
   input  logic [ELEMENT_WIDTH-1:0] req_right_slot_1,
   input  logic [ELEMENT_WIDTH-1:0] req_right_slot_2,
   input  logic [ELEMENT_WIDTH-1:0] req_right_slot_3,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_0,
   output logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_1,
   output logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_2,
   output logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_3,
   output logic                     rsp_saturated
);

   localparam int SLOTS = sstu_pkg::TAG_SLOTS;

   logic [ELEMENT_WIDTH-1:0]     left_in   [SLOTS];
   logic [ELEMENT_WIDTH-1:0]     right_in  [SLOTS];
   logic [SLOTS-1:0]             left_nonzero;
   logic [SLOTS-1:0]             left_live;
   sstu_pkg::lane_flags_type     flags_in  [SLOTS];
   logic [sstu_pkg::COUNT_W-1:0] count_in;
   logic                         full_in;

   logic [ELEMENT_WIDTH-1:0]     s1_left_ff  [SLOTS];
   logic [ELEMENT_WIDTH-1:0]     s1_right_ff [SLOTS];
   sstu_pkg::lane_flags_type     s1_flags_ff [SLOTS];
   logic [sstu_pkg::COUNT_W-1:0] s1_count_ff;
   logic                         s1_full_ff;
   logic                         s1_valid_ff;

   logic [ELEMENT_WIDTH-1:0]     merged_in   [SLOTS];
   logic                         sat_in;
   logic [ELEMENT_WIDTH-1:0]     s2_slots_ff [SLOTS];
   logic                         s2_sat_ff;
   logic                         s2_valid_ff;

   logic                         s1_en;
   logic                         s2_en;

   assign left_in[0]  = req_left_slot_0;
   assign left_in[1]  = req_left_slot_1;
   assign left_in[2]  = req_left_slot_2;
   assign left_in[3]  = req_left_slot_3;
   assign right_in[0] = req_right_slot_0;
   assign right_in[1] = req_right_slot_1;
   assign right_in[2] = req_right_slot_2;
   assign right_in[3] = req_right_slot_3;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         left_nonzero[i] = (left_in[i] != '0);
      end
   end

   assign left_live = sstu_pkg::prefix_mask(left_nonzero);
   assign count_in  = sstu_pkg::count_ones(left_live);
   assign full_in   = (left_in[0] == '1) || (right_in[0] == '1);

   for (genvar g = 0; g < SLOTS; g++) begin : g_lane
      sstu_lane #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .LANE_INDEX    (g)
      ) u_lane (
         .left_slots  (left_in),
         .right_slots (right_in),
         .left_live   (left_live),
         .flags       (flags_in[g])
      );
   end

   assign s2_en     = !s2_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_left_ff  <= left_in;
         s1_right_ff <= right_in;
         s1_flags_ff <= flags_in;
         s1_count_ff <= count_in;
         s1_full_ff  <= full_in;
      end
      if (s2_en) begin
         s2_slots_ff <= merged_in;
         s2_sat_ff   <= sat_in;
      end
   end

   sstu_merge #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_merge (
      .left_slots   (s1_left_ff),
      .right_slots  (s1_right_ff),
      .left_count   (s1_count_ff),
      .flags        (s1_flags_ff),
      .any_full     (s1_full_ff),
      .merged_slots (merged_in),
      .saturated    (sat_in)
   );

   assign rsp_valid         = s2_valid_ff;
   assign rsp_merged_slot_0 = s2_slots_ff[0];
   assign rsp_merged_slot_1 = s2_slots_ff[1];
   assign rsp_merged_slot_2 = s2_slots_ff[2];
   assign rsp_merged_slot_3 = s2_slots_ff[3];
   assign rsp_saturated     = s2_sat_ff;

endmodule

FILE: rtl/sstu_checker.sv
`include "small_tag_set_union_core_macros.svh"

module sstu_checker #(
   parameter int ELEMENT_WIDTH = sstu_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_0,
   input logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_1,
   input logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_2,
   input logic [ELEMENT_WIDTH-1:0] rsp_merged_slot_3,
   input logic                     rsp_saturated
);

   logic head_full;
   logic head_empty;
   logic tail_zero;

   assign head_full  = (rsp_merged_slot_0 == '1);
   assign head_empty = (rsp_merged_slot_0 == '0);
   assign tail_zero  = (rsp_merged_slot_1 == '0) && (rsp_merged_slot_2 == '0)
                       && (rsp_merged_slot_3 == '0);

   // With no result waiting, every pipeline stage can advance.
   `SSTU_ASSERT_IMPLY(a_idle_accepts, clock, reset, !rsp_valid, !req_stall)
   `SSTU_ASSERT_IMPLY(a_full_canonical, clock, reset, rsp_valid && rsp_saturated, head_full && tail_zero)
   `SSTU_ASSERT_IMPLY(a_empty_ends_set, clock, reset, rsp_valid && !rsp_saturated && head_empty, tail_zero)
   `SSTU_ASSERT_NEXT(a_stalled_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_merged_slot_0) && $stable(rsp_saturated))
   `SSTU_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind small_tag_set_union_core sstu_checker #(
   .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_sstu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_merged_slot_0 (rsp_merged_slot_0),
   .rsp_merged_slot_1 (rsp_merged_slot_1),
   .rsp_merged_slot_2 (rsp_merged_slot_2),
   .rsp_merged_slot_3 (rsp_merged_slot_3),
   .rsp_saturated     (rsp_saturated)
);

FILE: tb/sv/tb_small_tag_set_union_core.sv
`timescale 1ns / 1ps

module tb_small_tag_set_union_core;

   localparam int SLOTS = sstu_pkg::TAG_SLOTS;
   localparam int ELEMENT_WIDTH = sstu_pkg::ELEMENT_WIDTH_DEFAULT;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS = 210;

   typedef logic [ELEMENT_WIDTH-1:0] tag_type;
   typedef tag_type [SLOTS-1:0] tag_vec_type;
   typedef struct packed {
      tag_vec_type slot;
      logic        saturated;
   } merged_set_type;

   localparam tag_type EMPTY_TAG = '0;
   localparam tag_type FULL_TAG = '1;

   class union_scoreboard;
      merged_set_type expected_merges[$];
      int errors = 0;
      int merges_checked = 0;
      int saturated_seen = 0;
      int empty_seen = 0;

      function int live_slots(tag_vec_type s);
         int n;
         n = 0;
         while (n < SLOTS && s[n] != EMPTY_TAG) n++;
         return n;
      endfunction

      function merged_set_type union_of(tag_vec_type left, tag_vec_type right);
         merged_set_type full_set;
         merged_set_type merged;
         tag_vec_type    src;
         int             nl, nr, ns, n;
         bit             found;
         full_set.slot = '0;
         full_set.slot[0] = FULL_TAG;
         full_set.saturated = 1'b1;
         merged.slot = '0;
         merged.saturated = 1'b0;
         nl = live_slots(left);
         nr = live_slots(right);
         if (nl == 0 || nr == 0) begin
            src = (nl == 0) ? right : left;
            ns = (nl == 0) ? nr : nl;
            if (ns > 0 && src[0] == FULL_TAG) return full_set;
            for (int i = 0; i < ns; i++) merged.slot[i] = src[i];
            return merged;
         end
         if (left[0] == FULL_TAG || right[0] == FULL_TAG) return full_set;
         for (int i = 0; i < nl; i++) merged.slot[i] = left[i];
         n = nl;
         for (int j = 0; j < nr; j++) begin
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
               if (merged.slot[i] == right[j]) found = 1'b1;
            end
            if (!found) begin
               if (n >= SLOTS) return full_set;
               merged.slot[n] = right[j];
               n++;
            end
         end
         return merged;
      endfunction

      function void record_pair(tag_vec_type left, tag_vec_type right);
         expected_merges.push_back(union_of(left, right));
      endfunction

      function void check_merged(merged_set_type actual);
         merged_set_type want;
         if (expected_merges.size() == 0) begin
            errors++;
            $display("%0t: merged set arrived with none expected: slots %h saturated %b",
                     $time, actual.slot, actual.saturated);
            return;
         end
         want = expected_merges.pop_front();
         merges_checked++;
         if (want.saturated) saturated_seen++;
         if (want.slot[0] == EMPTY_TAG) empty_seen++;
         for (int i = 0; i < SLOTS; i++) begin
            if (actual.slot[i] !== want.slot[i]) begin
               errors++;
               $display("%0t: merged_slot_%0d expected %h actual %h",
                        $time, i, want.slot[i], actual.slot[i]);
            end
         end
         if (actual.saturated !== want.saturated) begin
            errors++;
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, actual.saturated);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tag_vec_type req_left = '0;
   tag_vec_type req_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tag_vec_type rsp_merged;
   logic rsp_saturated;

   union_scoreboard book = new();
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   tag_type shared_pool[6];
   int items_sent = 0;

   small_tag_set_union_core #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_slot_0  (req_left[0]),
      .req_left_slot_1  (req_left[1]),
      .req_left_slot_2  (req_left[2]),
      .req_left_slot_3  (req_left[3]),
      .req_right_slot_0 (req_right[0]),
      .req_right_slot_1 (req_right[1]),
      .req_right_slot_2 (req_right[2]),
      .req_right_slot_3 (req_right[3]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_slot_0(rsp_merged[0]),
      .rsp_merged_slot_1(rsp_merged[1]),
      .rsp_merged_slot_2(rsp_merged[2]),
      .rsp_merged_slot_3(rsp_merged[3]),
      .rsp_saturated    (rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         book.check_merged({rsp_merged, rsp_saturated});
      end
   end

   initial begin
      int wait_cycles;
      wait (reset == 1'b0);
      forever begin
         wait_cycles = recv_idle_on ? $urandom_range(0, 5) : 0;
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   task automatic send_sets(input tag_vec_type left, input tag_vec_type right);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_left <= left;
      req_right <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.record_pair(left, right);
      items_sent++;
   endtask

   task automatic drain_merges();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.expected_merges.size() != 0) @(posedge clock);
   endtask

   function automatic tag_vec_type slots(tag_type s0, tag_type s1, tag_type s2, tag_type s3);
      return {s3, s2, s1, s0};
   endfunction

   function automatic tag_type random_element();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick <= 6) return shared_pool[$urandom_range(0, 5)];
      if (pick == 7) return $urandom();
      if (pick == 8) return FULL_TAG;
      return $urandom_range(0, 1) ? tag_type'(1) << $urandom_range(0, ELEMENT_WIDTH - 1)
                                  : ~(tag_type'(1) << $urandom_range(0, ELEMENT_WIDTH - 1));
   endfunction

   function automatic tag_vec_type random_set();
      tag_vec_type s;
      int          shape;
      int          count;
      for (int i = 0; i < SLOTS; i++) s[i] = $urandom();
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         s[0] = EMPTY_TAG;
      end else if (shape < 18) begin
         s[0] = FULL_TAG;
      end else begin
         count = $urandom_range(1, SLOTS);
         for (int i = 0; i < count; i++) s[i] = random_element();
         if (count < SLOTS) s[count] = EMPTY_TAG;
      end
      return s;
   endfunction

   initial begin
      #2_000_000;
      $display("tb_small_tag_set_union_core NOT OK");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_sets(slots(0, 0, 0, 0), slots(0, 0, 0, 0));
      send_sets(slots(0, 32'h1234, 32'h5678, 0), slots(32'h11, 32'h22, 0, 32'h99));
      send_sets(slots(32'h1, 32'h2, 32'h3, 32'h4), slots(0, 32'hdead, 32'hbeef, 32'h7));
      send_sets(slots(FULL_TAG, 32'h5, 32'h6, 32'h7), slots(32'h1, 0, 0, 0));
      send_sets(slots(0, 32'h8, 0, 0), slots(FULL_TAG, 32'h3, 0, 32'h4));
      send_sets(slots(FULL_TAG, 0, 0, 0), slots(0, 0, 0, 0));
      send_sets(slots(FULL_TAG, FULL_TAG, 32'h1, 0), slots(FULL_TAG, 32'h2, 0, 0));
      send_sets(slots(32'h1, 32'h2, 0, 0), slots(FULL_TAG, 0, 0, 0));
      send_sets(slots(32'h1, FULL_TAG, 0, 0), slots(FULL_TAG - 1, FULL_TAG, 0, 0));
      send_sets(slots(32'h5, 32'h5, 32'h5, 0), slots(32'h5, 32'h6, 0, 0));
      send_sets(slots(32'h9, 0, 0, 0), slots(32'h7, 32'h7, 32'h7, 32'h7));
      send_sets(slots(32'h1, 32'h2, 32'h3, 0), slots(32'h3, 32'h2, 32'h1, 0));
      send_sets(slots(32'h1, 32'h2, 32'h3, 0), slots(32'h4, 32'h5, 0, 0));
      send_sets(slots(32'h1, 32'h2, 0, 0), slots(32'h3, 32'h4, 0, 0));
      send_sets(slots(32'ha, 32'hb, 32'hc, 32'hd), slots(32'hd, 32'hc, 32'hb, 32'ha));
      send_sets(slots(32'ha, 32'hb, 32'hc, 32'hd), slots(32'ha, 32'he, 0, 0));
      send_sets(slots(32'h1, 0, 32'hffff, 32'h4444), slots(32'h2, 0, 32'h3, 32'h1));
      send_sets(slots(32'h0000_0001, 32'h8000_0000, 0, 0),
                slots(32'hffff_fffe, 32'h7fff_ffff, 0, 0));
      send_sets(slots(32'h5555_5555, 32'haaaa_aaaa, 0, 0),
                slots(32'haaaa_aaaa, 32'h5555_5555, 0, 0));
      send_sets(slots(0, FULL_TAG, FULL_TAG, FULL_TAG), slots(0, FULL_TAG, 0, 0));
      drain_merges();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_on = (phase == 0 || phase == 3);
         recv_idle_on = (phase == 0 || phase == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            foreach (shared_pool[i]) shared_pool[i] = $urandom();
            send_sets(random_set(), random_set());
            if (k == PHASE_ITEMS / 2 && phase == 0) drain_merges();
         end
      end

      drain_merges();
      repeat (10) @(posedge clock);
      $display("Merged %0d pairs of tag sets (%0d directed, the rest random).",
               book.merges_checked, 20);
      $display("Saturated results: %0d, empty results: %0d.",
               book.saturated_seen, book.empty_seen);
      if (book.errors == 0 && book.expected_merges.size() == 0) begin
         $display("tb_small_tag_set_union_core OK");
      end else begin
         $display("tb_small_tag_set_union_core NOT OK");
      end
      $finish;
   end

endmodule
